/* rtl/core/ddpc_pkg.sv */
// Shared types and constants of the differential-drive PID controller.
// Used by ddpc_mac, ddpc_ctrl and differential_drive_pid_controller; no dependencies.
package ddpc_pkg;

    localparam int GAIN_W   = 16;
    localparam int MA_W     = 17;
    localparam int MB_W     = 32;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int ACC_W    = 50;
    localparam int SUM_W    = 32;
    localparam int PREV_W   = 24;
    localparam int BIAS_W   = PREV_W + 1;
    localparam int SERR_W   = 17;
    localparam int SPD_W    = 24;
    localparam int DUTY_W   = 14;
    localparam int LIMIT_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [LIMIT_W-1:0] DUTY_LIMIT  = 16'd8399;
    localparam logic [GAIN_W-1:0]  SCALE_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_KP,
        CFG_STEER_KI,
        CFG_STEER_KD,
        CFG_WHEEL_KP,
        CFG_WHEEL_KI,
        CFG_WHEEL_KD,
        CFG_HEADING_TARGET,
        CFG_SPEED_SCALE
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SPL,
        ST_SPR,
        ST_SKP,
        ST_SKI,
        ST_SKD,
        ST_SACC,
        ST_CORR,
        ST_ERR,
        ST_WUPD,
        ST_WLP,
        ST_WLI,
        ST_WLD,
        ST_WRP,
        ST_WRI,
        ST_WRD,
        ST_WRACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        A_SCALE,
        A_SKP,
        A_SKI,
        A_SKD,
        A_WKP,
        A_WKI,
        A_WKD
    } a_sel_t;

    typedef enum logic [3:0] {
        B_DL,
        B_DR,
        B_E,
        B_SUM0,
        B_BIAS0,
        B_EL,
        B_SUM1,
        B_BIAS1,
        B_ER,
        B_SUM2,
        B_BIAS2
    } b_sel_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        logic    lat_in;
        logic    upd_steer;
        logic    cap_spl;
        logic    cap_spr;
        logic    cap_corr;
        logic    cap_err;
        logic    upd_wheel;
        logic    cap_left;
        logic    load_out;
    } ctrl_t;

endpackage

/* rtl/core/ddpc_mac.sv */
// Shared 17x32 signed multiplier with registered product and a wide accumulator.
// Depends on ddpc_pkg.
module ddpc_mac (
    input  logic                               clk,
    input  ddpc_pkg::acc_op_t                  acc_op,
    input  logic signed [ddpc_pkg::MA_W-1:0]   mul_a,
    input  logic signed [ddpc_pkg::MB_W-1:0]   mul_b,
    output logic signed [ddpc_pkg::PROD_W-1:0] prod,
    output logic signed [ddpc_pkg::ACC_W-1:0]  acc
);
    import ddpc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        prod_next = mul_a * mul_b;
        acc_next  = acc_reg;
        case (acc_op)
            ACC_LOAD: acc_next = ACC_W'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

/* rtl/core/ddpc_ctrl.sv */
// Sequencer of the controller: steps the shared multiplier through one control tick.
// Depends on ddpc_pkg.
module ddpc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            out_free,
    output logic            s_tready,
    output ddpc_pkg::ctrl_t ctrl
);
    import ddpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = s_tvalid ? ST_SPL : ST_IDLE;
            ST_SPL:   state_next = ST_SPR;
            ST_SPR:   state_next = ST_SKP;
            ST_SKP:   state_next = ST_SKI;
            ST_SKI:   state_next = ST_SKD;
            ST_SKD:   state_next = ST_SACC;
            ST_SACC:  state_next = ST_CORR;
            ST_CORR:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_WUPD;
            ST_WUPD:  state_next = ST_WLP;
            ST_WLP:   state_next = ST_WLI;
            ST_WLI:   state_next = ST_WLD;
            ST_WLD:   state_next = ST_WRP;
            ST_WRP:   state_next = ST_WRI;
            ST_WRI:   state_next = ST_WRD;
            ST_WRD:   state_next = ST_WRACC;
            ST_WRACC: state_next = ST_DONE;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl       = '0;
        ctrl.a_sel = A_SCALE;
        ctrl.b_sel = B_DL;
        ctrl.acc_op = ACC_HOLD;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                ctrl.lat_in = s_tvalid;
            end
            ST_SPL:
            begin
                ctrl.upd_steer = 1'b1;
            end
            ST_SPR:
            begin
                ctrl.b_sel   = B_DR;
                ctrl.cap_spl = 1'b1;
            end
            ST_SKP:
            begin
                ctrl.a_sel   = A_SKP;
                ctrl.b_sel   = B_E;
                ctrl.cap_spr = 1'b1;
            end
            ST_SKI:
            begin
                ctrl.a_sel  = A_SKI;
                ctrl.b_sel  = B_SUM0;
                ctrl.acc_op = ACC_LOAD;
            end
            ST_SKD:
            begin
                ctrl.a_sel  = A_SKD;
                ctrl.b_sel  = B_BIAS0;
                ctrl.acc_op = ACC_ADD;
            end
            ST_SACC:
            begin
                ctrl.acc_op = ACC_ADD;
            end
            ST_CORR:
            begin
                ctrl.cap_corr = 1'b1;
            end
            ST_ERR:
            begin
                ctrl.cap_err = 1'b1;
            end
            ST_WUPD:
            begin
                ctrl.upd_wheel = 1'b1;
            end
            ST_WLP:
            begin
                ctrl.a_sel = A_WKP;
                ctrl.b_sel = B_EL;
            end
            ST_WLI:
            begin
                ctrl.a_sel  = A_WKI;
                ctrl.b_sel  = B_SUM1;
                ctrl.acc_op = ACC_LOAD;
            end
            ST_WLD:
            begin
                ctrl.a_sel  = A_WKD;
                ctrl.b_sel  = B_BIAS1;
                ctrl.acc_op = ACC_ADD;
            end
            ST_WRP:
            begin
                ctrl.a_sel  = A_WKP;
                ctrl.b_sel  = B_ER;
                ctrl.acc_op = ACC_ADD;
            end
            ST_WRI:
            begin
                ctrl.a_sel    = A_WKI;
                ctrl.b_sel    = B_SUM2;
                ctrl.acc_op   = ACC_LOAD;
                ctrl.cap_left = 1'b1;
            end
            ST_WRD:
            begin
                ctrl.a_sel  = A_WKD;
                ctrl.b_sel  = B_BIAS2;
                ctrl.acc_op = ACC_ADD;
            end
            ST_WRACC:
            begin
                ctrl.acc_op = ACC_ADD;
            end
            ST_DONE:
            begin
                ctrl.load_out = out_free;
            end
            default:
            begin
                ctrl.acc_op = ACC_HOLD;
            end
        endcase
    end

endmodule

/* rtl/core/differential_drive_pid_controller.sv */
// Differential-drive cascaded PID controller: steering PID feeding two wheel PIDs.
// Depends on ddpc_pkg, ddpc_mac and ddpc_ctrl.
//
// One control tick per input item. After an item is accepted s_tready stays low until the
// result has been loaded into the output register, so a new item is not taken before the
// last one is finished. The length of a tick is set by the eleven multiplications
// of a tick (two speed scalings, three steering terms, three terms per wheel) that all pass
// through the one 17x32 multiplier with its registered product, and by the wheel errors
// waiting on the finished steering correction. A finished result waits in the output
// register while the next item is accepted and computed.
module differential_drive_pid_controller #(
    parameter logic [ddpc_pkg::LIMIT_W-1:0] DUTY_LIMIT = ddpc_pkg::DUTY_LIMIT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_count[15:0], right_count[31:16], heading_measure[47:32],
    // base_left_speed[62:48], base_right_speed[77:63], force_turn[78], zero pad[79]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_duty[13:0], left_dir_level[14], right_duty[28:15], right_dir_level[29],
    // steer_correction[45:30], zero pad[47:46]
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [ddpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ddpc_pkg::GAIN_W-1:0]    cfg_data
);
    import ddpc_pkg::*;

    localparam int CORR_SRC_W = ACC_W - 16;
    localparam int WERR_W     = SPD_W + 2;
    localparam int MAG_W      = ACC_W - 8;

    ctrl_t ctrl;
    logic  out_free;

    logic signed [GAIN_W-1:0] steer_kp_reg;
    logic signed [GAIN_W-1:0] steer_ki_reg;
    logic signed [GAIN_W-1:0] steer_kd_reg;
    logic signed [GAIN_W-1:0] wheel_kp_reg;
    logic signed [GAIN_W-1:0] wheel_ki_reg;
    logic signed [GAIN_W-1:0] wheel_kd_reg;
    logic signed [GAIN_W-1:0] heading_target_reg;
    logic [GAIN_W-1:0]        speed_scale_reg;

    logic [15:0]              last_left_reg;
    logic [15:0]              last_right_reg;
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [PREV_W-1:0] prev_reg [3];

    logic signed [15:0]       dl_reg;
    logic signed [15:0]       dr_reg;
    logic signed [SERR_W-1:0] e_reg;
    logic signed [14:0]       bl_reg;
    logic signed [14:0]       br_reg;
    logic                     force_reg;
    logic signed [BIAS_W-1:0] bias_reg [3];
    logic signed [SPD_W-1:0]  spl_reg;
    logic signed [SPD_W-1:0]  spr_reg;
    logic signed [15:0]       corr_reg;
    logic signed [PREV_W-1:0] el_reg;
    logic signed [PREV_W-1:0] er_reg;
    logic [DUTY_W-1:0]        left_duty_reg;
    logic                     left_dir_reg;

    logic                     out_valid_reg;
    logic [DUTY_W-1:0]        out_left_duty_reg;
    logic                     out_left_dir_reg;
    logic [DUTY_W-1:0]        out_right_duty_reg;
    logic                     out_right_dir_reg;
    logic signed [15:0]       out_corr_reg;

    logic [15:0]              in_left_count;
    logic [15:0]              in_right_count;
    logic signed [15:0]       in_heading;
    logic signed [14:0]       in_base_left;
    logic signed [14:0]       in_base_right;
    logic                     in_force;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;

    logic                     drv_neg;
    logic [ACC_W-1:0]         drv_abs;
    logic [MAG_W-1:0]         drv_mag;
    logic [DUTY_W-1:0]        drv_duty;

    logic signed [SUM_W-1:0]  sum_upd [3];
    logic signed [15:0]       corr_sat;
    logic signed [PREV_W-1:0] el_sat;
    logic signed [PREV_W-1:0] er_sat;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            if (v[SUM_W] != v[SUM_W-1])
            begin
                r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                r = v[SUM_W-1:0];
            end
            return r;
        end
    endfunction

    function automatic logic signed [PREV_W-1:0] sat_err(input logic signed [WERR_W-1:0] v);
        logic signed [PREV_W-1:0] r;
        begin
            if (v > WERR_W'(signed'({1'b0, {(PREV_W-1){1'b1}}})))
            begin
                r = {1'b0, {(PREV_W-1){1'b1}}};
            end
            else if (v < -WERR_W'(signed'({1'b0, {(PREV_W-1){1'b1}}})) - WERR_W'(1))
            begin
                r = {1'b1, {(PREV_W-1){1'b0}}};
            end
            else
            begin
                r = v[PREV_W-1:0];
            end
            return r;
        end
    endfunction

    ddpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .s_tready (s_tready),
        .ctrl     (ctrl)
    );

    ddpc_mac u_mac (
        .clk    (clk),
        .acc_op (ctrl.acc_op),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .prod   (prod),
        .acc    (acc)
    );

    assign in_left_count  = s_tdata[15:0];
    assign in_right_count = s_tdata[31:16];
    assign in_heading     = s_tdata[47:32];
    assign in_base_left   = s_tdata[62:48];
    assign in_base_right  = s_tdata[77:63];
    assign in_force       = s_tdata[78];

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        case (ctrl.a_sel)
            A_SCALE: mul_a = MA_W'(speed_scale_reg);
            A_SKP:   mul_a = MA_W'(steer_kp_reg);
            A_SKI:   mul_a = MA_W'(steer_ki_reg);
            A_SKD:   mul_a = MA_W'(steer_kd_reg);
            A_WKP:   mul_a = MA_W'(wheel_kp_reg);
            A_WKI:   mul_a = MA_W'(wheel_ki_reg);
            A_WKD:   mul_a = MA_W'(wheel_kd_reg);
            default: mul_a = '0;
        endcase
        case (ctrl.b_sel)
            B_DL:    mul_b = MB_W'(dl_reg);
            B_DR:    mul_b = MB_W'(dr_reg);
            B_E:     mul_b = MB_W'(e_reg);
            B_SUM0:  mul_b = sum_reg[0];
            B_BIAS0: mul_b = MB_W'(bias_reg[0]);
            B_EL:    mul_b = MB_W'(el_reg);
            B_SUM1:  mul_b = sum_reg[1];
            B_BIAS1: mul_b = MB_W'(bias_reg[1]);
            B_ER:    mul_b = MB_W'(er_reg);
            B_SUM2:  mul_b = sum_reg[2];
            B_BIAS2: mul_b = MB_W'(bias_reg[2]);
            default: mul_b = '0;
        endcase
    end

    always_comb
    begin
        sum_upd[0] = sat_sum((SUM_W+1)'(sum_reg[0]) + (SUM_W+1)'(e_reg));
        sum_upd[1] = sat_sum((SUM_W+1)'(sum_reg[1]) + (SUM_W+1)'(el_reg));
        sum_upd[2] = sat_sum((SUM_W+1)'(sum_reg[2]) + (SUM_W+1)'(er_reg));
    end

    always_comb
    begin
        if (force_reg)
        begin
            corr_sat = '0;
        end
        else if ($signed(acc[ACC_W-1:16]) > CORR_SRC_W'(signed'(16'sh7FFF)))
        begin
            corr_sat = 16'sh7FFF;
        end
        else if ($signed(acc[ACC_W-1:16]) < CORR_SRC_W'(signed'(16'sh8000)))
        begin
            corr_sat = 16'sh8000;
        end
        else
        begin
            corr_sat = acc[31:16];
        end
        el_sat = sat_err(WERR_W'(bl_reg) - WERR_W'(corr_reg) - WERR_W'(spl_reg));
        er_sat = sat_err(WERR_W'(br_reg) + WERR_W'(corr_reg) - WERR_W'(spr_reg));
    end

    // Split the finished drive into magnitude and sign, clamped to DUTY_LIMIT; the fraction is truncated.
    always_comb
    begin
        drv_neg = acc[ACC_W-1];
        drv_abs = drv_neg ? ACC_W'(-acc) : ACC_W'(acc);
        drv_mag = drv_abs[ACC_W-1:8];
        if (drv_mag > MAG_W'(DUTY_LIMIT))
        begin
            drv_duty = DUTY_LIMIT[DUTY_W-1:0];
        end
        else
        begin
            drv_duty = drv_mag[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_kp_reg       <= '0;
            steer_ki_reg       <= '0;
            steer_kd_reg       <= '0;
            wheel_kp_reg       <= '0;
            wheel_ki_reg       <= '0;
            wheel_kd_reg       <= '0;
            heading_target_reg <= '0;
            speed_scale_reg    <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEER_KP:       steer_kp_reg       <= cfg_data;
                CFG_STEER_KI:       steer_ki_reg       <= cfg_data;
                CFG_STEER_KD:       steer_kd_reg       <= cfg_data;
                CFG_WHEEL_KP:       wheel_kp_reg       <= cfg_data;
                CFG_WHEEL_KI:       wheel_ki_reg       <= cfg_data;
                CFG_WHEEL_KD:       wheel_kd_reg       <= cfg_data;
                CFG_HEADING_TARGET: heading_target_reg <= cfg_data;
                CFG_SPEED_SCALE:    speed_scale_reg    <= cfg_data;
                default:            speed_scale_reg    <= speed_scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            sum_reg[0]     <= '0;
            sum_reg[1]     <= '0;
            sum_reg[2]     <= '0;
            prev_reg[0]    <= '0;
            prev_reg[1]    <= '0;
            prev_reg[2]    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.lat_in)
            begin
                last_left_reg  <= in_left_count;
                last_right_reg <= in_right_count;
            end
            if (ctrl.upd_steer)
            begin
                sum_reg[0]  <= sum_upd[0];
                prev_reg[0] <= PREV_W'(e_reg);
            end
            if (ctrl.upd_wheel)
            begin
                sum_reg[1]  <= sum_upd[1];
                sum_reg[2]  <= sum_upd[2];
                prev_reg[1] <= el_reg;
                prev_reg[2] <= er_reg;
            end
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.lat_in)
        begin
            dl_reg    <= in_left_count - last_left_reg;
            dr_reg    <= in_right_count - last_right_reg;
            e_reg     <= SERR_W'(heading_target_reg) - SERR_W'(in_heading);
            bl_reg    <= in_base_left;
            br_reg    <= in_base_right;
            force_reg <= in_force;
        end
        if (ctrl.upd_steer)
        begin
            bias_reg[0] <= BIAS_W'(e_reg) - BIAS_W'(prev_reg[0]);
        end
        if (ctrl.upd_wheel)
        begin
            bias_reg[1] <= BIAS_W'(el_reg) - BIAS_W'(prev_reg[1]);
            bias_reg[2] <= BIAS_W'(er_reg) - BIAS_W'(prev_reg[2]);
        end
        if (ctrl.cap_spl)
        begin
            spl_reg <= prod[SPD_W+7:8];
        end
        if (ctrl.cap_spr)
        begin
            spr_reg <= prod[SPD_W+7:8];
        end
        if (ctrl.cap_corr)
        begin
            corr_reg <= corr_sat;
        end
        if (ctrl.cap_err)
        begin
            el_reg <= el_sat;
            er_reg <= er_sat;
        end
        if (ctrl.cap_left)
        begin
            left_duty_reg <= drv_duty;
            left_dir_reg  <= !drv_neg;
        end
        if (ctrl.load_out)
        begin
            out_left_duty_reg  <= left_duty_reg;
            out_left_dir_reg   <= left_dir_reg;
            out_right_duty_reg <= drv_duty;
            out_right_dir_reg  <= drv_neg;
            out_corr_reg       <= corr_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_corr_reg, out_right_dir_reg, out_right_duty_reg,
                       out_left_dir_reg, out_left_duty_reg};

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a tick is in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten before it was taken");

    a_force_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cap_err |-> (!force_reg || corr_reg == 16'sd0))
        else $error("steering correction applied during forced turn");

    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DUTY_W-1:0] <= DUTY_LIMIT[DUTY_W-1:0]
                      && m_tdata[2*DUTY_W:DUTY_W+1] <= DUTY_LIMIT[DUTY_W-1:0]))
        else $error("duty above limit");

    a_valid_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> m_tvalid)
        else $error("result lost after load");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for differential_drive_pid_controller: drives control ticks,
// predicts each untyped drive result with its own cascaded PID model (typed rows give it) and compares every field.
// Depends on ddpc_pkg and the controller RTL only.
`timescale 1ns / 100ps

module testbench;

    import ddpc_pkg::*;

    typedef struct {
        logic [15:0]        lcount;
        logic [15:0]        rcount;
        logic signed [15:0] heading;
        logic signed [14:0] base_l;
        logic signed [14:0] base_r;
        logic               turn;
    } tick_t;

    typedef struct {
        logic [13:0] lduty;
        logic        ldir;
        logic [13:0] rduty;
        logic        rdir;
        logic [15:0] corr;
    } drive_t;

    typedef struct {
        bit          is_write;
        cfg_idx_t    reg_idx;
        logic [15:0] reg_value;
        tick_t       tick;
        bit          typed;
        drive_t      want;
    } step_row_t;

    typedef enum {
        GAINS_SMALL,
        GAINS_FULL,
        GAINS_EXTREME,
        GAINS_WINDUP
    } phase_kind_t;

    typedef enum {
        RX_STEADY,
        RX_DENSE,
        RX_SPARSE
    } rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    logic [15:0] gain_regs [0:7];
    logic [15:0] last_lcount;
    logic [15:0] last_rcount;
    longint      pid_sum [0:2];
    longint      pid_prev [0:2];

    drive_t      pending_drives [$];
    drive_t      no_drive;
    drive_t      head_drive;
    step_row_t   step_table [$];
    bit          offering;
    int          burst_left;
    int          fail_count;

    int          results_seen;
    int          hold_left;
    int          pattern_left;
    rx_mode_t    rx_mode;
    logic        rx_ready;

    phase_kind_t phase_plan [6] = '{GAINS_WINDUP, GAINS_SMALL, GAINS_FULL,
                                    GAINS_EXTREME, GAINS_SMALL, GAINS_EXTREME};

    differential_drive_pid_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint clamp_bits(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint pid_step(int idx, longint err, longint kp, longint ki,
                                        longint kd);
        longint bias;
        longint s;
        bias = err - pid_prev[idx];
        s = clamp_bits(pid_sum[idx] + err, 32);
        pid_sum[idx] = s;
        pid_prev[idx] = err;
        return kp * err + ki * s + kd * bias;
    endfunction

    function automatic void split_drive(input longint p, output logic [13:0] duty,
                                        output logic neg);
        longint mag;
        neg = p < 0;
        mag = ((p < 0) ? -p : p) >>> 8;
        if (mag > longint'(DUTY_LIMIT))
            mag = longint'(DUTY_LIMIT);
        duty = mag[13:0];
    endfunction

    function automatic drive_t predict_drive(tick_t t);
        logic [15:0] dlu;
        logic [15:0] dru;
        logic        neg;
        longint      skp, ski, skd, wkp, wki, wkd, target, scale;
        longint      dl, dr, spl, spr, corr, el, er, pl, pr;
        drive_t      d;
        skp    = longint'($signed(gain_regs[CFG_STEER_KP]));
        ski    = longint'($signed(gain_regs[CFG_STEER_KI]));
        skd    = longint'($signed(gain_regs[CFG_STEER_KD]));
        wkp    = longint'($signed(gain_regs[CFG_WHEEL_KP]));
        wki    = longint'($signed(gain_regs[CFG_WHEEL_KI]));
        wkd    = longint'($signed(gain_regs[CFG_WHEEL_KD]));
        target = longint'($signed(gain_regs[CFG_HEADING_TARGET]));
        scale  = longint'(gain_regs[CFG_SPEED_SCALE]);
        dlu = t.lcount - last_lcount;
        dru = t.rcount - last_rcount;
        dl  = longint'($signed(dlu));
        dr  = longint'($signed(dru));
        spl = (dl * scale) >>> 8;
        spr = (dr * scale) >>> 8;
        corr = clamp_bits(pid_step(0, target - longint'(t.heading), skp, ski, skd) >>> 16, 16);
        if (t.turn)
            corr = 0;
        el = clamp_bits((longint'(t.base_l) - corr) - spl, 24);
        er = clamp_bits((longint'(t.base_r) + corr) - spr, 24);
        pl = pid_step(1, el, wkp, wki, wkd);
        pr = pid_step(2, er, wkp, wki, wkd);
        split_drive(pl, d.lduty, neg);
        d.ldir = !neg;
        split_drive(pr, d.rduty, neg);
        d.rdir = neg;
        d.corr = corr[15:0];
        last_lcount = t.lcount;
        last_rcount = t.rcount;
        return d;
    endfunction

    task automatic check_field(string what, longint want, longint got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    task automatic send_tick(tick_t t, bit typed, drive_t want);
        drive_t d;
        if (!offering)
        begin
            s_tvalid <= 1'b1;
            offering = 1'b1;
        end
        s_tdata <= {1'b0, t.turn, t.base_r, t.base_l, t.heading, t.rcount, t.lcount};
        do
            @(posedge clk);
        while (!s_tready);
        d = predict_drive(t);
        pending_drives.push_back(typed ? want : d);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_drives.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        gain_regs[idx] = v;
        @(posedge clk);
    endtask

    task automatic add_write(cfg_idx_t idx, logic [15:0] v);
        step_row_t r;
        r.is_write  = 1'b1;
        r.reg_idx   = idx;
        r.reg_value = v;
        r.tick      = '{default: '0};
        r.typed     = 1'b0;
        r.want      = '{default: '0};
        step_table.push_back(r);
    endtask

    task automatic add_tick(logic [15:0] lc, logic [15:0] rc, logic [15:0] hd,
                            logic [14:0] bl, logic [14:0] br, logic turn);
        step_row_t r;
        r.is_write     = 1'b0;
        r.reg_idx      = CFG_STEER_KP;
        r.reg_value    = '0;
        r.typed        = 1'b0;
        r.want         = '{default: '0};
        r.tick.lcount  = lc;
        r.tick.rcount  = rc;
        r.tick.heading = hd;
        r.tick.base_l  = bl;
        r.tick.base_r  = br;
        r.tick.turn    = turn;
        step_table.push_back(r);
    endtask

    task automatic expect_last(logic [13:0] ld, logic lr, logic [13:0] rd, logic rr,
                               logic [15:0] corr);
        step_row_t r;
        r = step_table.pop_back();
        r.typed      = 1'b1;
        r.want.lduty = ld;
        r.want.ldir  = lr;
        r.want.rduty = rd;
        r.want.rdir  = rr;
        r.want.corr  = corr;
        step_table.push_back(r);
    endtask

    task automatic program_phase(phase_kind_t kind);
        logic [15:0] v;
        for (int i = 0; i < 8; i++)
        begin
            if (cfg_idx_t'(i) == CFG_SPEED_SCALE)
            begin
                case (kind)
                    GAINS_SMALL:   v = 16'($urandom_range(0, 640));
                    GAINS_FULL:    v = 16'($urandom);
                    GAINS_WINDUP:  v = 16'hFFFF;
                    default:
                        case ($urandom_range(0, 3))
                            0:       v = 16'h0000;
                            1:       v = 16'hFFFF;
                            2:       v = 16'h0001;
                            default: v = SCALE_RESET;
                        endcase
                endcase
            end
            else
            begin
                case (kind)
                    GAINS_SMALL:   v = 16'($urandom_range(0, 1536)) - 16'd768;
                    GAINS_FULL:    v = 16'($urandom);
                    GAINS_WINDUP:  v = 16'($urandom_range(0, 512)) - 16'd256;
                    default:
                        case ($urandom_range(0, 3))
                            0:       v = 16'h8000;
                            1:       v = 16'h7FFF;
                            2:       v = 16'h0000;
                            default: v = 16'hFFFF;
                        endcase
                endcase
            end
            write_reg(cfg_idx_t'(i), v);
        end
    endtask

    function automatic tick_t draw_tick(phase_kind_t kind);
        tick_t t;
        if (kind == GAINS_WINDUP)
        begin
            // hold both wheels near full-scale speed of opposite sign
            t.lcount = last_lcount + 16'h8000 + 16'($urandom_range(0, 63));
            t.rcount = last_rcount + 16'h7FFF - 16'($urandom_range(0, 63));
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            t.lcount = last_lcount + 16'($urandom_range(0, 600)) - 16'd300;
            t.rcount = last_rcount + 16'($urandom_range(0, 600)) - 16'd300;
        end
        else
        begin
            t.lcount = 16'($urandom);
            t.rcount = 16'($urandom);
        end
        if ($urandom_range(0, 1) == 0)
            t.heading = 16'($urandom);
        else
            t.heading = gain_regs[CFG_HEADING_TARGET] + 16'($urandom_range(0, 800)) - 16'd400;
        t.base_l = 15'($urandom);
        t.base_r = 15'($urandom);
        t.turn   = ($urandom_range(0, 3) == 0);
        return t;
    endfunction

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_drives.size() == 0)
            begin
                $display("%0t ns: unexpected result %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                head_drive = pending_drives.pop_front();
                check_field("left_duty", head_drive.lduty, m_tdata[13:0]);
                check_field("left_dir_level", head_drive.ldir, m_tdata[14]);
                check_field("right_duty", head_drive.rduty, m_tdata[28:15]);
                check_field("right_dir_level", head_drive.rdir, m_tdata[29]);
                check_field("steer_correction", $signed(head_drive.corr),
                            $signed(m_tdata[45:30]));
            end
            results_seen++;
            if (results_seen % 370 == 150)
                hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rx_ready = 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            case (rx_mode)
                RX_STEADY: rx_ready = 1'b1;
                RX_DENSE:  rx_ready = ($urandom_range(0, 3) != 0);
                default:   rx_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_tready <= rx_ready;
    end

    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        step_row_t r;
        int        n;
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        offering  = 1'b0;
        burst_left = 0;
        fail_count = 0;
        results_seen = 0;
        hold_left = 0;
        pattern_left = 0;
        rx_mode = RX_STEADY;
        no_drive = '{default: 0};
        for (int i = 0; i < 8; i++)
            gain_regs[i] = '0;
        gain_regs[CFG_SPEED_SCALE] = SCALE_RESET;
        last_lcount = '0;
        last_rcount = '0;
        for (int i = 0; i < 3; i++)
        begin
            pid_sum[i]  = 0;
            pid_prev[i] = 0;
        end

        // zero gains after reset: no drive whatever the inputs
        add_tick(16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 1'b0);
        expect_last(14'd0, 1'b1, 14'd0, 1'b0, 16'h0000);
        add_tick(16'hFFFF, 16'hFFFF, 16'h8000, 15'h4000, 15'h4000, 1'b1);
        expect_last(14'd0, 1'b1, 14'd0, 1'b0, 16'h0000);
        add_tick(16'h8000, 16'h7FFF, 16'h7FFF, 15'h3FFF, 15'h3FFF, 1'b0);
        expect_last(14'd0, 1'b1, 14'd0, 1'b0, 16'h0000);
        // small negative drive
        add_write(CFG_WHEEL_KP, 16'hFFFF);
        add_tick(16'h8000, 16'h7FFF, 16'h0000, 15'd5, 15'd3, 1'b0);
        expect_last(14'd0, 1'b0, 14'd0, 1'b1, 16'h0000);
        // clamp at the duty limit both ways
        add_write(CFG_WHEEL_KP, 16'h7FFF);
        add_tick(16'h8000, 16'h7FFF, 16'h0000, 15'h3FFF, 15'h4000, 1'b0);
        expect_last(14'd8399, 1'b1, 14'd8399, 1'b1, 16'h0000);
        add_tick(16'h8000, 16'h7FFF, 16'h0000, 15'h0000, 15'h0000, 1'b0);
        expect_last(14'd0, 1'b1, 14'd0, 1'b0, 16'h0000);
        add_write(CFG_WHEEL_KP, 16'h8000);
        add_write(CFG_WHEEL_KI, 16'h7FFF);
        add_write(CFG_WHEEL_KD, 16'h8000);
        add_tick(16'h8000, 16'h7FFF, 16'd100, -15'sd200, 15'sd300, 1'b0);
        add_tick(16'h8000, 16'h7FFF, -16'sd100, 15'sd1000, -15'sd1000, 1'b1);
        // saturated correction, forced turn, wheel error saturation
        add_write(CFG_STEER_KP, 16'h7FFF);
        add_write(CFG_STEER_KI, 16'h7FFF);
        add_write(CFG_STEER_KD, 16'h8000);
        add_write(CFG_HEADING_TARGET, 16'h7FFF);
        add_write(CFG_SPEED_SCALE, 16'hFFFF);
        add_tick(16'h8000, 16'h7FFF, 16'h8000, 15'h0000, 15'h0000, 1'b0);
        add_tick(16'h8000, 16'h7FFF, 16'h8000, 15'h0000, 15'h0000, 1'b1);
        add_tick(16'hFFFF, 16'hFFFF, 16'h8000, 15'h4000, 15'h3FFF, 1'b0);
        add_tick(16'h7FFE, 16'h7FFF, 16'h8000, 15'h4000, 15'h3FFF, 1'b0);
        add_write(CFG_SPEED_SCALE, 16'h0000);
        add_write(CFG_HEADING_TARGET, 16'h8000);
        add_tick(16'h1234, 16'hEDCB, 16'h7FFF, 15'h1555, 15'h2AAA, 1'b0);
        add_tick(16'h0000, 16'h0000, 16'h0000, 15'h3FFF, 15'h4000, 1'b1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        while (step_table.size() != 0)
        begin
            r = step_table.pop_front();
            if (r.is_write)
                write_reg(r.reg_idx, r.reg_value);
            else
                send_tick(r.tick, r.typed, r.want);
        end

        foreach (phase_plan[p])
        begin
            program_phase(phase_plan[p]);
            n = (phase_plan[p] == GAINS_WINDUP) ? 320 : 90;
            repeat (n) send_tick(draw_tick(phase_plan[p]), 1'b0, no_drive);
        end

        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_drives.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
